### rtl/csbr_pkg.sv
package csbr_pkg;

    // Field widths
    localparam int PERIOD_W = 16;
    localparam int EXP_W    = 4;
    localparam int COLL_W   = 8;
    localparam int STAT_W   = 3;
    localparam int TXCNT_W  = 5;
    localparam int LEN_W    = 8;
    localparam int RND_W    = 16;
    localparam int ACT_W    = 2;
    localparam int DELAY_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    // Widest exponent is 2^EXP_W - 1, so (2^BE - 1) * period fits in this width
    localparam int MAXD_W   = PERIOD_W + (1 << EXP_W) - 1;

    // One remainder bit per step over the random value
    localparam int DIV_STEPS = RND_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd128;
    localparam logic [EXP_W-1:0]    EXP_RST    = 4'd4;
    localparam logic [COLL_W-1:0]   COLL_RST   = 8'd10;
    localparam logic [COLL_W-1:0]   COLL_SAT   = 8'd255;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACKOFF_PERIOD = 2'd0,
        CFG_MAX_EXPONENT   = 2'd1,
        CFG_MAX_COLLISIONS = 2'd2
    } cfg_index_t;

    // Report kinds
    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_REPORT = 1'b1
    } kind_t;

    // Transmit status codes; unlisted codes count as other error
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_ACK    = 3'd1,
        ST_COLLISION = 3'd2,
        ST_DEFERRED  = 3'd3,
        ST_OTHER     = 3'd4
    } tx_status_t;

    // Result actions
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_RETRY = 2'd1,
        ACT_OK    = 2'd2,
        ACT_DROP  = 2'd3
    } action_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_maxd;
        logic div_step;
        logic emit;
    } csbr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_backoff;
        logic out_free;
    } csbr_stat_t;

endpackage

### rtl/csbr_if.sv
// Report channel: one load or transmit result per beat
interface csbr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic [csbr_pkg::STAT_W-1:0]   tx_status;
    logic [csbr_pkg::TXCNT_W-1:0]  tx_count;
    logic [csbr_pkg::LEN_W-1:0]    frame_length;
    logic [csbr_pkg::RND_W-1:0]    random_value;

    modport source (
        output valid, kind, tx_status, tx_count, frame_length, random_value,
        input  ready
    );
    modport sink (
        input  valid, kind, tx_status, tx_count, frame_length, random_value,
        output ready
    );
endinterface

// Result channel: one result per beat
interface csbr_out_if;
    logic                          valid;
    logic                          ready;
    logic [csbr_pkg::ACT_W-1:0]    action;
    logic [csbr_pkg::DELAY_W-1:0]  delay_ticks;
    logic [csbr_pkg::COLL_W-1:0]   collision_total;
    logic [csbr_pkg::LEN_W-1:0]    held_length;

    modport source (
        output valid, action, delay_ticks, collision_total, held_length,
        input  ready
    );
    modport sink (
        input  valid, action, delay_ticks, collision_total, held_length,
        output ready
    );
endinterface

### rtl/csma_backoff_retry_controller_top.sv
// Retry controller for one cached frame with binary exponential backoff. Each report beat
// gives exactly one result beat. Loads, ok, deferred, drops and errors go from accept
// straight to the result register; a collision that schedules a retry is accepted, then
// forms (2^BE-1)*period, runs the bit-serial remainder over the 16-bit random value and
// registers the result. A new report is taken only once the previous result is
// in the output register, which may still be waiting on the sink. Configuration writes
// (index 0 period, 1 max exponent, 2 max collisions) must be issued while no report is in
// flight.
module csma_backoff_retry_controller_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csbr_pkg::CFG_DATA_W-1:0] cfg_data,
    csbr_in_if.sink                         report,
    csbr_out_if.source                      result
);

    csbr_pkg::csbr_cmd_t  cmd;
    csbr_pkg::csbr_stat_t stat;
    logic                 in_ready;

    assign report.ready = in_ready;

    // Sequencer
    csbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    csbr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .kind            (report.kind),
        .tx_status       (report.tx_status),
        .tx_count        (report.tx_count),
        .frame_length    (report.frame_length),
        .random_value    (report.random_value),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (result.valid),
        .out_ready       (result.ready),
        .action          (result.action),
        .delay_ticks     (result.delay_ticks),
        .collision_total (result.collision_total),
        .held_length     (result.held_length)
    );

endmodule

### rtl/csbr_ctrl.sv
// Sequencer: accept, build max delay, run remainder steps, emit result
module csbr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csbr_pkg::csbr_stat_t stat,
    output csbr_pkg::csbr_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MAXD = 4'b0010,
        S_DIV  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    state_t                        state_reg, state_next;
    logic [csbr_pkg::STEP_W-1:0]   step_reg, step_next;

    localparam logic [csbr_pkg::STEP_W-1:0] LAST_STEP =
        csbr_pkg::STEP_W'(csbr_pkg::DIV_STEPS - 1);

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        cmd.accept    = 1'b0;
        cmd.load_maxd = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.emit      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = stat.need_backoff ? S_MAXD : S_EMIT;
                end
            end
            S_MAXD:
            begin
                cmd.load_maxd = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

### rtl/csbr_datapath.sv
// Config, frame state, backoff arithmetic and the result register
module csbr_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [csbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csbr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            kind,
    input  logic [csbr_pkg::STAT_W-1:0]     tx_status,
    input  logic [csbr_pkg::TXCNT_W-1:0]    tx_count,
    input  logic [csbr_pkg::LEN_W-1:0]      frame_length,
    input  logic [csbr_pkg::RND_W-1:0]      random_value,
    input  csbr_pkg::csbr_cmd_t             cmd,
    output csbr_pkg::csbr_stat_t            stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [csbr_pkg::ACT_W-1:0]      action,
    output logic [csbr_pkg::DELAY_W-1:0]    delay_ticks,
    output logic [csbr_pkg::COLL_W-1:0]     collision_total,
    output logic [csbr_pkg::LEN_W-1:0]      held_length
);

    localparam int MAXD_W = csbr_pkg::MAXD_W;
    localparam int RND_W  = csbr_pkg::RND_W;

    // Configuration
    logic [csbr_pkg::PERIOD_W-1:0] period_reg;
    logic [csbr_pkg::EXP_W-1:0]    max_exp_reg;
    logic [csbr_pkg::COLL_W-1:0]   max_coll_reg;

    // Frame state
    logic [csbr_pkg::COLL_W-1:0]   coll_reg, coll_next;
    logic [csbr_pkg::LEN_W-1:0]    len_reg, len_next;

    // Work registers
    csbr_pkg::action_t             act_reg, act_next;
    logic [csbr_pkg::EXP_W-1:0]    be_reg, be_next;
    logic [RND_W-1:0]              dvd_reg;
    logic [RND_W-1:0]              rem_reg;
    logic [MAXD_W-1:0]             maxd_reg;

    // Result register
    logic                          out_valid_reg;
    csbr_pkg::action_t             out_act_reg;
    logic [csbr_pkg::DELAY_W-1:0]  out_delay_reg;
    logic [csbr_pkg::COLL_W-1:0]   out_coll_reg;
    logic [csbr_pkg::LEN_W-1:0]    out_len_reg;

    logic [csbr_pkg::COLL_W:0]     coll_sum;
    logic [csbr_pkg::COLL_W-1:0]   coll_sat;
    logic [RND_W:0]                rem_shift;
    logic                          rem_ge;
    logic [RND_W:0]                delay_sum;
    logic [csbr_pkg::DELAY_W-1:0]  delay_val;

    // Configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= csbr_pkg::PERIOD_RST;
            max_exp_reg  <= csbr_pkg::EXP_RST;
            max_coll_reg <= csbr_pkg::COLL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csbr_pkg::CFG_BACKOFF_PERIOD: period_reg   <= cfg_data;
                csbr_pkg::CFG_MAX_EXPONENT:   max_exp_reg  <= cfg_data[csbr_pkg::EXP_W-1:0];
                csbr_pkg::CFG_MAX_COLLISIONS: max_coll_reg <= cfg_data[csbr_pkg::COLL_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturating collision total
    assign coll_sum = {1'b0, coll_reg} + {{(csbr_pkg::COLL_W + 1 - csbr_pkg::TXCNT_W){1'b0}},
                                          tx_count};
    assign coll_sat = coll_sum[csbr_pkg::COLL_W] ? csbr_pkg::COLL_SAT
                                                 : coll_sum[csbr_pkg::COLL_W-1:0];

    // Decode of an accepted beat
    always_comb
    begin
        coll_next = coll_reg;
        len_next  = len_reg;
        act_next  = csbr_pkg::ACT_NONE;
        be_next   = be_reg;
        if (kind == csbr_pkg::KIND_LOAD)
        begin
            len_next  = frame_length;
            coll_next = '0;
        end
        else
        begin
            unique case (tx_status)
                csbr_pkg::ST_OK:
                begin
                    len_next  = '0;
                    coll_next = '0;
                    act_next  = csbr_pkg::ACT_OK;
                end
                csbr_pkg::ST_DEFERRED:
                begin
                    act_next = csbr_pkg::ACT_NONE;
                end
                csbr_pkg::ST_COLLISION:
                begin
                    if (coll_sat > max_coll_reg)
                    begin
                        len_next  = '0;
                        coll_next = '0;
                        act_next  = csbr_pkg::ACT_DROP;
                    end
                    else
                    begin
                        coll_next = coll_sat;
                        act_next  = csbr_pkg::ACT_RETRY;
                        // BE = min(count, max exponent)
                        be_next   = (coll_sat < {{(csbr_pkg::COLL_W - csbr_pkg::EXP_W){1'b0}},
                                                 max_exp_reg})
                                    ? coll_sat[csbr_pkg::EXP_W-1:0] : max_exp_reg;
                    end
                end
                default:
                begin
                    // no ack and any other error drop the frame
                    len_next  = '0;
                    coll_next = '0;
                    act_next  = csbr_pkg::ACT_DROP;
                end
            endcase
        end
    end

    assign stat.need_backoff = (act_next == csbr_pkg::ACT_RETRY);
    assign stat.out_free     = !out_valid_reg || out_ready;

    // One restoring remainder step
    assign rem_shift = {rem_reg, dvd_reg[RND_W-1]};
    assign rem_ge    = {{(MAXD_W - RND_W - 1){1'b0}}, rem_shift} >= maxd_reg;

    // delay = period/2 + random mod maxd for a retry; zero for other actions or when maxd is zero
    assign delay_sum = {2'b00, period_reg[csbr_pkg::PERIOD_W-1:1]} + {1'b0, rem_reg};
    always_comb
    begin
        delay_val = '0;
        if (act_reg == csbr_pkg::ACT_RETRY && maxd_reg != '0)
        begin
            delay_val = csbr_pkg::DELAY_W'(delay_sum);
        end
    end

    // Frame state and work registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coll_reg <= '0;
            len_reg  <= '0;
        end
        else if (cmd.accept)
        begin
            coll_reg <= coll_next;
            len_reg  <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg <= act_next;
            be_reg  <= be_next;
            dvd_reg <= random_value;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[RND_W-2:0], 1'b0};
            rem_reg <= rem_ge ? RND_W'(rem_shift - maxd_reg[RND_W:0]) : rem_shift[RND_W-1:0];
        end
        if (cmd.load_maxd)
        begin
            // (2^BE - 1) * period as a shift and subtract
            maxd_reg <= (MAXD_W'(period_reg) << be_reg) - MAXD_W'(period_reg);
            rem_reg  <= '0;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_act_reg   <= act_reg;
            out_delay_reg <= delay_val;
            out_coll_reg  <= coll_reg;
            out_len_reg   <= len_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = out_act_reg;
    assign delay_ticks     = out_delay_reg;
    assign collision_total = out_coll_reg;
    assign held_length     = out_len_reg;

endmodule
